[hdl/vpnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpnc_pkg
// Shared types and constants of the varint packed number codec.
// ----------------------------------------------------------------------------
package vpnc_pkg;

  // longest encoded number in bytes
  localparam int unsigned MaxBytes = 10;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  localparam logic [7:0] GroupMask = 8'h7f;
  localparam logic [7:0] ContBit   = 8'h80;

  // item kinds
  localparam logic KindEncode = 1'b0;
  localparam logic KindDecode = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StEncMap,
    StEncByte,
    StDecAcc,
    StDecOut
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch input item
    logic enc_map;   // apply sign mapping to the value
    logic enc_load;  // emit next encoded byte into the output register
    logic dec_acc;   // merge decode byte into the accumulator
    logic dec_load;  // emit decode result into the output register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic kind;      // kind of the captured item
    logic enc_last;  // byte about to be emitted is the last one
  } status_t;

endpackage

[hdl/vpnc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpnc_ctrl
// Sequencer of the codec: input handshake, steps of each item and the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module vpnc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  vpnc_pkg::status_t status_i,
  output vpnc_pkg::cmd_t    cmd_o
);

  vpnc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  // output register can take a new item
  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vpnc_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = vpnc_pkg::StEncMap;
        end
      end
      vpnc_pkg::StEncMap: begin
        state_d = (status_i.kind == vpnc_pkg::KindDecode) ? vpnc_pkg::StDecAcc
                                                          : vpnc_pkg::StEncByte;
      end
      vpnc_pkg::StEncByte: begin
        if (slot_free && status_i.enc_last) begin
          state_d = vpnc_pkg::StIdle;
        end
      end
      vpnc_pkg::StDecAcc: begin
        state_d = vpnc_pkg::StDecOut;
      end
      vpnc_pkg::StDecOut: begin
        if (slot_free) begin
          state_d = vpnc_pkg::StIdle;
        end
      end
      default: begin
        state_d = vpnc_pkg::StIdle;
      end
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      vpnc_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      vpnc_pkg::StEncMap: begin
        cmd_o.enc_map = (status_i.kind == vpnc_pkg::KindEncode);
      end
      vpnc_pkg::StEncByte: begin
        cmd_o.enc_load = slot_free;
      end
      vpnc_pkg::StDecAcc: begin
        cmd_o.dec_acc = 1'b1;
      end
      vpnc_pkg::StDecOut: begin
        cmd_o.dec_load = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd_o.enc_load || cmd_o.dec_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vpnc_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/vpnc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpnc_dp
// Datapath of the codec: encode shift register, decode accumulator and
// the output register.
// ----------------------------------------------------------------------------
module vpnc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vpnc_pkg::cmd_t      cmd_i,
  output vpnc_pkg::status_t   status_o,
  input  logic                kind_i,
  input  logic                signed_form_i,
  input  logic [63:0]         value_in_i,
  input  logic [7:0]          byte_in_i,
  output logic [7:0]          byte_out_o,
  output logic                last_byte_o,
  output logic                overflow_flag_o,
  output logic                number_done_o,
  output logic [63:0]         decoded_value_o
);

  // captured item
  logic                      kind_q;
  logic                      sgn_q;
  logic [63:0]               val_q, val_d;
  logic [7:0]                byte_q;
  logic                      ovf_q, ovf_d;
  logic [vpnc_pkg::CntW-1:0] nb_q;

  // decode state
  logic [63:0]               acc_q, acc_d;
  logic [vpnc_pkg::CntW-1:0] cnt_q;
  logic                      done_q;

  // output register
  logic [7:0]                byte_out_q;
  logic                      last_q, ovf_out_q, done_out_q;
  logic [63:0]               dec_out_q;

  logic [63:0]               mag;
  logic [6:0]                sh;
  logic                      dec_done;
  logic [63:0]               dec_res;
  logic                      enc_last;
  logic [7:0]                enc_byte;

  // sign mapping of the encode value
  assign mag = 64'd0 - val_q;
  always_comb begin
    val_d = val_q << 1;
    ovf_d = 1'b0;
    if (sgn_q && val_q[63]) begin
      val_d = {mag[62:0], 1'b1};
      ovf_d = (val_q == {1'b1, 63'd0});
    end else if (!sgn_q) begin
      val_d = val_q;
    end
  end

  // next encoded byte
  assign enc_last = (val_q[63:7] == 57'd0) ||
                    (nb_q == vpnc_pkg::CntW'(vpnc_pkg::MaxBytes - 1));
  assign enc_byte = enc_last ? (val_q[7:0] & vpnc_pkg::GroupMask)
                             : ((val_q[7:0] & vpnc_pkg::GroupMask) | vpnc_pkg::ContBit);

  // decode accumulation
  assign sh       = 7'(cnt_q) * 7'd7;
  assign dec_done = !byte_q[7] ||
                    ({1'b0, cnt_q} + 1'b1 >= (vpnc_pkg::CntW + 1)'(vpnc_pkg::MaxBytes));
  always_comb begin
    acc_d = acc_q;
    if (sh < 7'd64) begin
      acc_d = acc_q | (64'(byte_q[6:0]) << sh[5:0]);
    end
  end

  // sign unmapping of the decoded number
  assign dec_res = !sgn_q ? acc_q : (acc_q[0] ? (64'd0 - {1'b0, acc_q[63:1]})
                                              : {1'b0, acc_q[63:1]});

  assign status_o.kind     = kind_q;
  assign status_o.enc_last = enc_last;

  // item and encode registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      sgn_q  <= signed_form_i;
      val_q  <= value_in_i;
      byte_q <= byte_in_i;
      nb_q   <= '0;
    end else if (cmd_i.enc_map) begin
      val_q  <= val_d;
      ovf_q  <= ovf_d;
    end else if (cmd_i.enc_load) begin
      val_q  <= val_q >> 7;
      nb_q   <= nb_q + 1'b1;
    end
    if (cmd_i.dec_acc) begin
      done_q <= dec_done;
    end
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.dec_acc) begin
      acc_q <= acc_d;
      cnt_q <= dec_done ? '0 : cnt_q + 1'b1;
    end else if (cmd_i.dec_load && done_q) begin
      acc_q <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.enc_load) begin
      byte_out_q <= enc_byte;
      last_q     <= enc_last;
      ovf_out_q  <= ovf_q;
      done_out_q <= 1'b0;
      dec_out_q  <= '0;
    end else if (cmd_i.dec_load) begin
      byte_out_q <= '0;
      last_q     <= 1'b0;
      ovf_out_q  <= 1'b0;
      done_out_q <= done_q;
      dec_out_q  <= done_q ? dec_res : 64'd0;
    end
  end

  assign byte_out_o      = byte_out_q;
  assign last_byte_o     = last_q;
  assign overflow_flag_o = ovf_out_q;
  assign number_done_o   = done_out_q;
  assign decoded_value_o = dec_out_q;

endmodule

[hdl/varint_packed_number_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_packed_number_codec
// LEB128 style codec: encodes a 64-bit value into one to ten bytes, or
// accumulates one incoming byte of an encoded number per decode item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_ready_o   | kind, signed_form, value_in, byte_in
//  out     | output    | out_valid_o/out_ready_i | byte_out, last_byte, overflow_flag,
//          |           |                         | number_done, decoded_value
//
//  encode: accept, then sign mapping, then one byte per cycle while the
//  output register can take it; decode passes accept, map, accumulate and output.
//  the output register holding one item sets the pace of the byte loop;
//  a stalled output holds the loop, and the next item is taken while the
//  last result still waits. reset clears the decode accumulator and count.
// ----------------------------------------------------------------------------
module varint_packed_number_codec (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        signed_form_i,
  input  logic [63:0] value_in_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic        last_byte_o,
  output logic        overflow_flag_o,
  output logic        number_done_o,
  output logic [63:0] decoded_value_o
);

  vpnc_pkg::cmd_t    cmd;
  vpnc_pkg::status_t status;

  // sequencer
  vpnc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  vpnc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (kind_i),
    .signed_form_i   (signed_form_i),
    .value_in_i      (value_in_i),
    .byte_in_i       (byte_in_i),
    .byte_out_o      (byte_out_o),
    .last_byte_o     (last_byte_o),
    .overflow_flag_o (overflow_flag_o),
    .number_done_o   (number_done_o),
    .decoded_value_o (decoded_value_o)
  );

endmodule

[bench/tb_varint_packed_number_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_varint_packed_number_codec
// Self-checking bench for the LEB128 style number codec. Encode and decode
// items go in over a valid/ready channel with random gaps, and every result
// byte or decode status is compared against an in-bench model of the codec.
// A long output stall fills the block up while items keep being offered.
// ----------------------------------------------------------------------------
module tb_varint_packed_number_codec;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 200;
  localparam int unsigned CalmItems  = 70;
  localparam int unsigned IdlePct    = 17;
  localparam int unsigned HoldCycles = 300;

  // one result item of the codec
  typedef struct packed {
    logic [7:0]  enc_byte;
    logic        last_flag;
    logic        ovf_flag;
    logic        done_flag;
    logic [63:0] dec_value;
  } codec_res_t;

  // codec model plus the queue of results still owed by the block
  class varint_checker;
    codec_res_t  awaited_out[$];
    logic [63:0] dec_acc;
    logic [3:0]  dec_cnt;
    int unsigned errors;

    function new();
      dec_acc = '0;
      dec_cnt = '0;
      errors  = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    // work out the results of one accepted item
    function void note_item(logic kind, logic sgn, logic [63:0] val, logic [7:0] din);
      logic [63:0] v;
      logic [63:0] mag;
      logic [63:0] res;
      logic        ovf;
      logic        done;
      int unsigned n;
      int unsigned sh;
      int unsigned cnt;
      codec_res_t  r;
      if (kind == vpnc_pkg::KindEncode) begin
        v   = val;
        ovf = 1'b0;
        // sign goes into bit zero, magnitude shifted up
        if (sgn) begin
          if (!v[63]) begin
            v = v << 1;
          end else begin
            mag = -v;
            ovf = (mag == 64'h8000_0000_0000_0000);
            v   = (mag << 1) | 64'd1;
          end
        end
        n = 0;
        do begin
          r          = '0;
          r.enc_byte = v[7:0] & vpnc_pkg::GroupMask;
          r.ovf_flag = ovf;
          v          = v >> 7;
          n++;
          if (v != 0 && n < vpnc_pkg::MaxBytes) r.enc_byte = r.enc_byte | vpnc_pkg::ContBit;
          else r.last_flag = 1'b1;
          awaited_out.push_back(r);
        end while (!r.last_flag);
      end else begin
        r   = '0;
        sh  = dec_cnt * 7;
        // a tenth group only keeps its low bit
        if (sh < 64) dec_acc = dec_acc | ({56'd0, din & vpnc_pkg::GroupMask} << sh);
        cnt  = dec_cnt + 1;
        done = !din[7] || (cnt >= vpnc_pkg::MaxBytes);
        if (done) begin
          res = dec_acc;
          if (sgn) res = res[0] ? -(res >> 1) : (res >> 1);
          r.done_flag = 1'b1;
          r.dec_value = res;
          dec_acc     = '0;
          dec_cnt     = '0;
        end else begin
          dec_cnt = cnt[3:0];
        end
        awaited_out.push_back(r);
      end
    endfunction

    // compare one accepted result with the oldest owed one
    task check_result(codec_res_t got);
      codec_res_t want;
      if (awaited_out.size() == 0) begin
        report("result with nothing owed, byte_out", {56'd0, got.enc_byte}, 64'd0);
        return;
      end
      want = awaited_out.pop_front();
      if (got.enc_byte !== want.enc_byte)
        report("byte_out", {56'd0, got.enc_byte}, {56'd0, want.enc_byte});
      if (got.last_flag !== want.last_flag)
        report("last_byte", {63'd0, got.last_flag}, {63'd0, want.last_flag});
      if (got.ovf_flag !== want.ovf_flag)
        report("overflow_flag", {63'd0, got.ovf_flag}, {63'd0, want.ovf_flag});
      if (got.done_flag !== want.done_flag)
        report("number_done", {63'd0, got.done_flag}, {63'd0, want.done_flag});
      if (got.dec_value !== want.dec_value)
        report("decoded_value", got.dec_value, want.dec_value);
    endtask
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic        kind_i          = vpnc_pkg::KindEncode;
  logic        signed_form_i   = 1'b0;
  logic [63:0] value_in_i      = '0;
  logic [7:0]  byte_in_i       = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [7:0]  byte_out_o;
  logic        last_byte_o;
  logic        overflow_flag_o;
  logic        number_done_o;
  logic [63:0] decoded_value_o;

  varint_checker sb;
  bit            calm      = 1'b0;
  bit            stall_go  = 1'b0;
  int unsigned   rand_sent = 0;
  int unsigned   cycle_cnt = 0;

  varint_packed_number_codec u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .signed_form_i  (signed_form_i),
    .value_in_i     (value_in_i),
    .byte_in_i      (byte_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_out_o     (byte_out_o),
    .last_byte_o    (last_byte_o),
    .overflow_flag_o(overflow_flag_o),
    .number_done_o  (number_done_o),
    .decoded_value_o(decoded_value_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // offer one item from a falling edge, return at the falling edge after acceptance
  task automatic send_item(logic kind, logic sgn, logic [63:0] val, logic [7:0] din);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    kind_i        = kind;
    signed_form_i = sgn;
    value_in_i    = val;
    byte_in_i     = din;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(kind, sgn, val, din);
    @(negedge clk_i);
  endtask

  // one random encode, decode run or stray byte
  task automatic random_step();
    int unsigned pick;
    int unsigned nbits;
    int unsigned len;
    logic [63:0] v;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // encode with a random bit length so every byte count shows up
      nbits = $urandom_range(1, 64);
      v     = {$urandom, $urandom};
      if (nbits < 64) v = v & ((64'd1 << nbits) - 64'd1);
      if ($urandom_range(3) == 0) v = -v;
      send_item(vpnc_pkg::KindEncode, 1'($urandom_range(1)), v, 8'($urandom));
      rand_sent++;
    end else if (pick < 90) begin
      // well formed number of one to ten bytes
      len = $urandom_range(1, 10);
      for (int unsigned i = 0; i < len; i++) begin
        b = 8'($urandom_range(255));
        if (i < len - 1) b[7] = 1'b1;
        else if (len < vpnc_pkg::MaxBytes) b[7] = 1'b0;
        send_item(vpnc_pkg::KindDecode, 1'($urandom_range(1)), {$urandom, $urandom}, b);
        rand_sent++;
      end
    end else begin
      // stray byte
      send_item(vpnc_pkg::KindDecode, 1'($urandom_range(1)), {$urandom, $urandom},
                8'($urandom_range(255)));
      rand_sent++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (stall_go) begin
        stall_go = 1'b0;
        hold     = HoldCycles;
      end
      if (hold > 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = calm || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{byte_out_o, last_byte_o, overflow_flag_o, number_done_o,
                        decoded_value_o});
  end

  // main sequence
  initial begin
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // encode extremes: zero, all ones, signed corner values
    send_item(vpnc_pkg::KindEncode, 1'b0, 64'd0, 8'h00);
    send_item(vpnc_pkg::KindEncode, 1'b0, 64'hffff_ffff_ffff_ffff, 8'hff);
    send_item(vpnc_pkg::KindEncode, 1'b1, 64'h8000_0000_0000_0000, 8'h00);
    send_item(vpnc_pkg::KindEncode, 1'b1, 64'hffff_ffff_ffff_ffff, 8'h00);
    send_item(vpnc_pkg::KindEncode, 1'b1, 64'h4000_0000_0000_0000, 8'h00);
    send_item(vpnc_pkg::KindEncode, 1'b1, 64'hc000_0000_0000_0000, 8'h00);
    send_item(vpnc_pkg::KindEncode, 1'b1, 64'h7fff_ffff_ffff_ffff, 8'h00);
    send_item(vpnc_pkg::KindEncode, 1'b1, 64'd0, 8'h00);

    // negative zero decodes to zero
    send_item(vpnc_pkg::KindDecode, 1'b1, 64'd0, 8'h01);
    // two byte number
    send_item(vpnc_pkg::KindDecode, 1'b0, 64'hffff_ffff_ffff_ffff, 8'h80);
    send_item(vpnc_pkg::KindDecode, 1'b0, 64'd0, 8'h01);
    // ten bytes all with continuation, high bits of the tenth dropped
    for (int unsigned i = 0; i < vpnc_pkg::MaxBytes; i++)
      send_item(vpnc_pkg::KindDecode, 1'b1, 64'd0, 8'hff);

    // random part: a calm stretch, then a long output stall with idling
    calm = 1'b1;
    while (rand_sent < CalmItems) random_step();
    calm     = 1'b0;
    stall_go = 1'b1;
    while (rand_sent < RandItems) random_step();
    in_valid_i = 1'b0;

    // drain
    while (sb.awaited_out.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited_out.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
